>>> hdl/fwsm_pkg.sv
// Shared types and constants for the focal weighted squared-difference unit.
`timescale 1ns / 1ps
package fwsm_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int BANDS       = 4;
  localparam int SAMPLE_BITS = 16;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int EW     = $clog2(MAX_WIDTH + 1);
  localparam int BW     = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int SQ_W   = 2 * SAMPLE_BITS;
  localparam int PROD_W = SQ_W + 8;
  localparam int DIST_W = 45;
  localparam int ROW_W  = 16;

  typedef struct packed {
    logic [BANDS-1:0][SAMPLE_BITS-1:0] smp;
    logic                              miss;
  } pixel_t;

  typedef struct packed {
    pixel_t [8:0]     win;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [3:0]       en;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_WEIGHTS
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } back_state_t;

endpackage

>>> hdl/fwsm_front.sv
// Front end: pixel intake, raster counters, line buffers and 3x3 window.
`timescale 1ns / 1ps
module fwsm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fwsm_pkg::pixel_t     in_pix,
  input  logic [fwsm_pkg::EW-1:0]    eff_w,
  input  logic [fwsm_pkg::ROW_W-1:0] eff_h,
  input  logic                 restart,
  input  fwsm_pkg::q_stat_t    q_stat,
  output logic                 q_push,
  output fwsm_pkg::job_t       q_job
);
  import fwsm_pkg::*;

  pixel_t line_a [MAX_WIDTH];
  pixel_t line_b [MAX_WIDTH];

  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;

  logic             s2_v_r;
  pixel_t           s2_pix_r;
  logic [ROW_W-1:0] s2_row_r;
  logic [COL_W-1:0] s2_col_r;
  pixel_t           rda_r, rdb_r, fa_r, fb_r;
  logic             fwd_r;

  pixel_t       win_r [9];
  pixel_t [8:0] win_nxt;
  pixel_t       a_eff, b_eff;
  logic [3:0]   en;
  logic         s2_fire, accept, top_ok, last_row, last_col;

  assign a_eff    = fwd_r ? fa_r : rda_r;
  assign b_eff    = fwd_r ? fb_r : rdb_r;
  assign top_ok   = (s2_row_r != '0);
  assign last_row = (s2_row_r == eff_h - 1'b1);
  assign last_col = (EW'(s2_col_r) == eff_w - 1'b1);

  always_comb begin
    en[0] = top_ok && (s2_col_r != '0);
    en[1] = top_ok && last_col;
    en[2] = last_row && (s2_col_r != '0);
    en[3] = last_row && last_col;
  end

  // shift the window one column left and bring in the new column
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3]   = win_r[r*3+1];
      win_nxt[r*3+1] = win_r[r*3+2];
    end
    win_nxt[2] = b_eff;
    win_nxt[5] = a_eff;
    win_nxt[8] = s2_pix_r;
  end

  assign s2_fire  = s2_v_r && (!(|en) || !q_stat.full);
  assign in_ready = !s2_v_r || s2_fire;
  assign accept   = in_valid && in_ready;
  assign q_push   = s2_fire && (|en);

  always_comb begin
    q_job.win = win_nxt;
    q_job.row = s2_row_r;
    q_job.col = s2_col_r;
    q_job.en  = en;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      s2_v_r <= 1'b0;
    end else begin
      if (restart) begin
        row_r <= '0;
        col_r <= '0;
      end else if (accept) begin
        if ((EW + 1)'(col_r) + 1'b1 >= (EW + 1)'(eff_w)) begin
          col_r <= '0;
          if ((ROW_W + 1)'(row_r) + 1'b1 >= (ROW_W + 1)'(eff_h)) begin
            row_r <= '0;
          end else begin
            row_r <= row_r + 1'b1;
          end
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
      if (accept) begin
        s2_v_r <= 1'b1;
      end else if (s2_fire) begin
        s2_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_pix_r <= in_pix;
      s2_row_r <= row_r;
      s2_col_r <= col_r;
      rda_r    <= line_a[col_r];
      rdb_r    <= line_b[col_r];
      // a write to the same column lands this edge: forward it
      fwd_r    <= s2_fire && (s2_col_r == col_r);
      fa_r     <= s2_pix_r;
      fb_r     <= a_eff;
    end
    if (s2_fire) begin
      line_a[s2_col_r] <= s2_pix_r;
      line_b[s2_col_r] <= a_eff;
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

endmodule

>>> hdl/fwsm_queue.sv
// Two-entry job queue between front end and arithmetic back end.
`timescale 1ns / 1ps
module fwsm_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  fwsm_pkg::job_t     push_job,
  input  logic               pop,
  output fwsm_pkg::job_t     head,
  output fwsm_pkg::q_stat_t  stat
);
  import fwsm_pkg::*;

  job_t       mem_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= ~wr_r;
      if (do_pop)  rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_job;
  end

endmodule

>>> hdl/fwsm_back.sv
// Back end: per-result sequencer, squared-difference MAC and output register.
`timescale 1ns / 1ps
module fwsm_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fwsm_pkg::job_t              head,
  input  fwsm_pkg::q_stat_t           q_stat,
  output logic                        pop,
  input  logic [fwsm_pkg::EW-1:0]     eff_w,
  input  logic [fwsm_pkg::ROW_W-1:0]  eff_h,
  input  logic [63:0]                 weights,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fwsm_pkg::DIST_W-1:0] out_distance,
  output logic                        out_result_no_data,
  output logic [15:0]                 out_row,
  output logic [9:0]                  out_col,
  output logic                        out_last_of_run
);
  import fwsm_pkg::*;

  back_state_t state_r, state_nxt;
  job_t        job_r;
  logic [1:0]  slot_r;
  logic [2:0]  nb_r;
  logic [BW-1:0] band_r;

  logic              p1_v_r, p2_v_r;
  logic [SQ_W-1:0]   sq_r;
  logic [7:0]        wt_r;
  logic [PROD_W-1:0] prod_r;
  logic [DIST_W-1:0] acc_r;
  logic              out_valid_r;

  logic              pass, right, nd, out_load, start, step_last;
  logic [1:0]        wr, wc;
  logic [3:0]        centre;
  logic [ROW_W-1:0]  q;
  logic [COL_W-1:0]  col;
  logic [7:0]        nv;
  logic [3:0]        nidx [8];
  logic [1:0]        head_slot, next_slot;
  logic              next_found;
  logic [SAMPLE_BITS-1:0] sa, sb, ad;

  assign pass   = slot_r[1];
  assign right  = slot_r[0];
  assign wr     = pass ? 2'd2 : 2'd1;
  assign wc     = right ? 2'd2 : 2'd1;
  assign centre = 4'(wr * 3 + wc);
  assign q      = pass ? job_r.row : job_r.row - 1'b1;
  assign col    = right ? job_r.col : job_r.col - 1'b1;

  // neighbour clipping and window index for each of the eight neighbours
  always_comb begin
    int pos, dr, dc, ni;
    for (int n = 0; n < 8; n++) begin
      pos = (n < 4) ? n : n + 1;
      dr  = pos / 3 - 1;
      dc  = pos % 3 - 1;
      nv[n] = !((q == '0) && (dr < 0)) && !((q == eff_h - 1'b1) && (dr > 0)) &&
              !((col == '0) && (dc < 0)) &&
              !((EW'(col) == eff_w - 1'b1) && (dc > 0)) &&
              !(pass && (dr > 0)) && !(right && (dc > 0));
      ni = (int'(wr) + dr) * 3 + int'(wc) + dc;
      nidx[n] = nv[n] ? 4'(ni) : centre;
    end
  end

  always_comb begin
    nd = job_r.win[centre].miss;
    for (int n = 0; n < 8; n++) begin
      if (nv[n] && job_r.win[nidx[n]].miss) nd = 1'b1;
    end
  end

  always_comb begin
    head_slot = 2'd3;
    for (int s = 3; s >= 0; s--) begin
      if (head.en[s]) head_slot = 2'(s);
    end
    next_found = 1'b0;
    next_slot  = slot_r;
    for (int s = 3; s >= 0; s--) begin
      if (job_r.en[s] && (2'(s) > slot_r)) begin
        next_found = 1'b1;
        next_slot  = 2'(s);
      end
    end
  end

  assign sa        = job_r.win[centre].smp[band_r];
  assign sb        = job_r.win[nidx[nb_r]].smp[band_r];
  assign ad        = (sa > sb) ? sa - sb : sb - sa;
  assign step_last = (nb_r == 3'd7) && (band_r == BW'(BANDS - 1));
  assign out_load  = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    start     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          start     = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!p1_v_r && !p2_v_r) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) begin
          if (next_found) begin
            start     = 1'b1;
            state_nxt = ST_RUN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      p1_v_r  <= (state_r == ST_RUN);
      p2_v_r  <= p1_v_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r  <= head;
      slot_r <= head_slot;
    end else if (out_load && next_found) begin
      slot_r <= next_slot;
    end
    if (start) begin
      nb_r   <= '0;
      band_r <= '0;
    end else if (state_r == ST_RUN) begin
      if (band_r == BW'(BANDS - 1)) begin
        band_r <= '0;
        nb_r   <= nb_r + 1'b1;
      end else begin
        band_r <= band_r + 1'b1;
      end
    end
    sq_r   <= SQ_W'(ad) * SQ_W'(ad);
    wt_r   <= nv[nb_r] ? weights[8*nb_r +: 8] : 8'd0;
    prod_r <= PROD_W'(sq_r) * PROD_W'(wt_r);
    if (start) begin
      acc_r <= '0;
    end else if (p2_v_r) begin
      acc_r <= acc_r + DIST_W'(prod_r);
    end
    if (out_load) begin
      out_distance       <= nd ? '0 : acc_r;
      out_result_no_data <= nd;
      out_row            <= q;
      out_col            <= 10'(col);
      out_last_of_run    <= !next_found;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> hdl/focal_weighted_sqdiff_multiband_unit.sv
// Top level of the weighted 3x3 focal squared-difference unit.
`timescale 1ns / 1ps
// Usage:
//  - Input channel (in_*): one pixel per transfer in raster order, four bands and a
//    no-data flag. The front end takes a pixel every cycle while the job queue has room.
//  - Result channel (out_*): per pixel, the weighted sum of squared band differences
//    to its in-image neighbours, with row, column and a last-of-run flag on the final
//    result caused by one input. Results trail the input by one row and one column;
//    the last row is delivered while it arrives.
//  - Configuration (cfg_*): width, height and eight 8-bit weights; any write to a
//    register restarts the frame at row 0, column 0. Write only while idle.
//  - Sequencing: the back end walks 8 neighbours x 4 bands through one squarer and
//    one weight multiplier; each result is a fetch, one step per neighbour and band,
//    a pipeline drain and an emit; further results of the same job skip the fetch.
//    Pixels that cause no result never occupy the back end.
//  - Path: the line-buffer read is registered at the transfer and the window is updated as
//    the job is queued; the job then waits in the queue for the back end to fetch it.
//  - Reset: synchronous, active low; counters, queue and handshakes clear. Line
//    buffers and window are not cleared; unwritten entries only feed clipped positions.
//  - Stall: a stalled receiver holds the output register; the back end and then the
//    two-entry queue fill, and only then is in_ready dropped.
module focal_weighted_sqdiff_multiband_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_band0,
  input  logic [15:0] in_band1,
  input  logic [15:0] in_band2,
  input  logic [15:0] in_band3,
  input  logic        in_no_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [44:0] out_distance,
  output logic        out_result_no_data,
  output logic [15:0] out_row,
  output logic [9:0]  out_col,
  output logic        out_last_of_run,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);
  import fwsm_pkg::*;

  logic [10:0]      width_r;
  logic [15:0]      height_r;
  logic [63:0]      weights_r;
  logic             restart;
  logic [EW-1:0]    eff_w;
  logic [ROW_W-1:0] eff_h;
  pixel_t           in_pix;
  logic [15:0]      bands [4];
  job_t             q_job, q_head;
  q_stat_t          q_stat;
  logic             q_push, q_pop;

  // take the samples of the configured bands, masked to sample width
  assign bands[0] = in_band0;
  assign bands[1] = in_band1;
  assign bands[2] = in_band2;
  assign bands[3] = in_band3;
  always_comb begin
    for (int b = 0; b < BANDS; b++) begin
      in_pix.smp[b] = bands[b][SAMPLE_BITS-1:0];
    end
    in_pix.miss = in_no_data;
  end

  // clamp the geometry: zero acts as one, width saturates at the line-buffer size
  always_comb begin
    if (width_r == '0) begin
      eff_w = EW'(1);
    end else if (width_r > MAX_WIDTH) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(width_r);
    end
    eff_h = (height_r == '0) ? ROW_W'(1) : height_r;
  end

  always_comb begin
    restart = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH, REG_HEIGHT, REG_WEIGHTS: restart = 1'b1;
        default: restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= 11'd1024;
      height_r  <= 16'd1024;
      weights_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:   width_r   <= cfg_wdata[10:0];
        REG_HEIGHT:  height_r  <= cfg_wdata[15:0];
        REG_WEIGHTS: weights_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  fwsm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_pix   (in_pix),
    .eff_w    (eff_w),
    .eff_h    (eff_h),
    .restart  (restart),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_job    (q_job)
  );

  fwsm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  fwsm_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (q_head),
    .q_stat             (q_stat),
    .pop                (q_pop),
    .eff_w              (eff_w),
    .eff_h              (eff_h),
    .weights            (weights_r),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_distance       (out_distance),
    .out_result_no_data (out_result_no_data),
    .out_row            (out_row),
    .out_col            (out_col),
    .out_last_of_run    (out_last_of_run)
  );

endmodule
